[design/cctm_pkg.sv]
// ============================================================================
// cctm_pkg: shared types and step functions for the ciphertext tensor block
// Holds the per-stage payload and the one-bit remainder and multiply steps.
// ============================================================================
`default_nettype none

package cctm_pkg;

    localparam int CoefW   = 62;
    localparam int InDataW = 312;
    localparam int OutDataW = 192;
    localparam int NumBits = CoefW;
    localparam int NumStg  = 2 * CoefW;

    // Operands: raw coefficients while reducing, reduced ones while multiplying.
    // Accumulators: remainders while reducing, partial products while multiplying.
    typedef struct packed {
        logic [CoefW-1:0]            q;
        logic [3:0][CoefW-1:0]       opnd;
        logic [3:0][CoefW-1:0]       acc;
        logic                        err;
        logic                        last;
    } stage_t;

    // One restoring remainder step: shift in one dividend bit, subtract if fits
    function automatic logic [CoefW-1:0] red_step(
        input logic [CoefW-1:0] r,
        input logic             bitv,
        input logic [CoefW-1:0] q
    );
        logic [CoefW:0] t;
        t = {r, bitv};
        if (t >= {1'b0, q})
            t = t - {1'b0, q};
        return t[CoefW-1:0];
    endfunction

    // One shift-and-add modular multiply step on one multiplier bit
    function automatic logic [CoefW-1:0] mul_step(
        input logic [CoefW-1:0] r,
        input logic [CoefW-1:0] a,
        input logic             bitv,
        input logic [CoefW-1:0] q
    );
        logic [CoefW+1:0] t;
        t = {1'b0, r, 1'b0};
        if (t >= {2'b00, q})
            t = t - {2'b00, q};
        if (bitv)
        begin
            t = t + {2'b00, a};
            if (t >= {2'b00, q})
                t = t - {2'b00, q};
        end
        return t[CoefW-1:0];
    endfunction

endpackage

`default_nettype wire

[design/ckks_ciphertext_tensor_mod.sv]
// ============================================================================
// ckks_ciphertext_tensor_mod: modular tensor product of two ciphertexts
// Per RNS coefficient gives x0*y0, x0*y1+x1*y0 and x1*y1 modulo the limb
// modulus, with a range flag for coefficients not below the modulus.
// ============================================================================
//
//  channel   | dir | tdata                                   | tuser       | tlast
//  ----------+-----+-----------------------------------------+-------------+----------
//  s_axis    | in  | first_a, first_b, second_a, second_b,   | -           | last_item
//            |     | modulus (62 bits each)                  |             |
//  m_axis    | out | term_zero, term_one, term_two           | range_error | last_out
//
//  One transaction per cycle is sustained while the output is not stalled; an input
//  transaction passes through 125 register stages before its result is valid.
//  62 stages reduce the coefficients one remainder bit each, 62 stages run the
//  four shift-and-add products one multiplier bit each, one stage adds and
//  registers the result. Reset clears only the valid bits.
//  A stall at m_axis with a result waiting freezes the whole pipeline; s_axis_tready follows it.
//
`default_nettype none

module ckks_ciphertext_tensor_mod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_a [61:0], first_b [123:62], second_a [185:124],
    // second_b [247:186], modulus [309:248], zero [311:310]
    input  wire logic [cctm_pkg::InDataW-1:0]  s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // term_zero [61:0], term_one [123:62], term_two [185:124], zero [191:186]
    output logic [cctm_pkg::OutDataW-1:0]      m_axis_tdata,
    // range_error [0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import cctm_pkg::*;

    stage_t              st_reg [0:NumStg-1];
    logic [NumStg-1:0]   vld_reg;
    logic [CoefW-1:0]    t0_reg, t1_reg, t2_reg;
    logic                err_reg, last_reg, ovld_reg;
    logic                adv;
    stage_t              in_st;

    // Advance when the output slot is empty or being taken
    assign adv           = !ovld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Unpack the input transaction and flag out-of-range coefficients
    always_comb
    begin
        in_st.q       = s_axis_tdata[5*CoefW-1 -: CoefW];
        in_st.opnd[0] = s_axis_tdata[1*CoefW-1 -: CoefW];
        in_st.opnd[1] = s_axis_tdata[2*CoefW-1 -: CoefW];
        in_st.opnd[2] = s_axis_tdata[3*CoefW-1 -: CoefW];
        in_st.opnd[3] = s_axis_tdata[4*CoefW-1 -: CoefW];
        in_st.acc     = '0;
        in_st.err     = (in_st.opnd[0] >= in_st.q) || (in_st.opnd[1] >= in_st.q) ||
                        (in_st.opnd[2] >= in_st.q) || (in_st.opnd[3] >= in_st.q);
        in_st.last    = s_axis_tlast;
    end

    genvar s;
    generate
        for (s = 0; s < NumStg; s++)
        begin : g_stage
            localparam int BitIdx = NumBits - 1 - (s % NumBits);
            stage_t src;
            stage_t st_next;
            logic   vld_src;

            // Pick the previous stage; at the phase boundary move remainders to operands
            if (s == 0)
            begin : g_head
                always_comb
                begin
                    src     = in_st;
                    vld_src = s_axis_tvalid;
                end
            end
            else if (s == NumBits)
            begin : g_turn
                always_comb
                begin
                    src      = st_reg[s-1];
                    src.opnd = st_reg[s-1].acc;
                    src.acc  = '0;
                    vld_src  = vld_reg[s-1];
                end
            end
            else
            begin : g_body
                always_comb
                begin
                    src     = st_reg[s-1];
                    vld_src = vld_reg[s-1];
                end
            end

            // Process one bit of every lane
            always_comb
            begin
                st_next = src;
                if (s < NumBits)
                begin
                    for (int j = 0; j < 4; j++)
                        st_next.acc[j] = red_step(src.acc[j], src.opnd[j][BitIdx], src.q);
                end
                else
                begin
                    for (int j = 0; j < 4; j++)
                        st_next.acc[j] = mul_step(src.acc[j], src.opnd[j >> 1],
                                                  src.opnd[2 + (j & 1)][BitIdx], src.q);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s] <= 1'b0;
                else if (adv)
                    vld_reg[s] <= vld_src;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    st_reg[s] <= st_next;
            end
        end
    endgenerate

    // Final stage: add the cross terms, zero the three terms for a zero modulus
    stage_t           fin;
    logic [CoefW:0]   sum;
    logic [CoefW-1:0] t0_next, t1_next, t2_next;
    logic             qz;

    always_comb
    begin
        fin = st_reg[NumStg-1];
        qz  = (fin.q == '0);
        sum = {1'b0, fin.acc[1]} + {1'b0, fin.acc[2]};
        if (sum >= {1'b0, fin.q})
            sum = sum - {1'b0, fin.q};
        t0_next = qz ? '0 : fin.acc[0];
        t1_next = qz ? '0 : sum[CoefW-1:0];
        t2_next = qz ? '0 : fin.acc[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (adv)
            ovld_reg <= vld_reg[NumStg-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg   <= t0_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            err_reg  <= fin.err;
            last_reg <= fin.last;
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {{(OutDataW - 3*CoefW){1'b0}}, t2_reg, t1_reg, t0_reg};
    assign m_axis_tuser  = err_reg;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ============================================================================
// tb: stream testbench for the ciphertext tensor block
// Drives coefficient transactions with random gaps and stalls, predicts the
// three modular products with an independent model and checks each result.
// ============================================================================
`default_nettype none

module tb;

    localparam int W = cctm_pkg::CoefW;

    typedef struct packed {
        logic          last;
        logic [W-1:0]  q;
        logic [W-1:0]  yb;
        logic [W-1:0]  ya;
        logic [W-1:0]  xb;
        logic [W-1:0]  xa;
    } coef_t;

    typedef struct packed {
        logic          last;
        logic          err;
        logic [W-1:0]  t2;
        logic [W-1:0]  t1;
        logic [W-1:0]  t0;
    } tensor_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [cctm_pkg::InDataW-1:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [cctm_pkg::OutDataW-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;
    logic s_axis_tready_q;

    coef_t   pending_q[$];
    tensor_t expected_q[$];
    int      gap_pct;
    int      stall_pct;
    int      hold_cycles;
    int      fail_cnt;

    ckks_ciphertext_tensor_mod dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Modular product by long multiplication with full-width intermediate
    function automatic logic [W-1:0] prod_mod(logic [W-1:0] a, logic [W-1:0] b,
                                              logic [W-1:0] q);
        logic [2*W-1:0] p;
        p = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        return W'(p % {{W{1'b0}}, q});
    endfunction

    function automatic tensor_t tensor_product(coef_t c);
        tensor_t r;
        logic [W-1:0] a0, a1, b0, b1;
        logic [W:0]   s;
        r = '0;
        r.last = c.last;
        r.err = (c.xa >= c.q) || (c.xb >= c.q) || (c.ya >= c.q) || (c.yb >= c.q);
        if (c.q != '0)
        begin
            a0 = c.xa % c.q;
            a1 = c.xb % c.q;
            b0 = c.ya % c.q;
            b1 = c.yb % c.q;
            r.t0 = prod_mod(a0, b0, c.q);
            r.t2 = prod_mod(a1, b1, c.q);
            s = {1'b0, prod_mod(a0, b1, c.q)} + {1'b0, prod_mod(a1, b0, c.q)};
            if (s >= {1'b0, c.q})
                s = s - {1'b0, c.q};
            r.t1 = s[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [W-1:0] rand_coef();
        return W'({$urandom(), $urandom()});
    endfunction

    // Value below q, biased toward the edges
    function automatic logic [W-1:0] rand_below(logic [W-1:0] q);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return q - 1;
            default: return rand_coef() % q;
        endcase
    endfunction

    function automatic logic [W-1:0] rand_modulus();
        case ($urandom_range(0, 7))
            0: return {W{1'b1}};
            1: return W'($urandom_range(2, 1000));
            2: return W'({1'b1, W'(0)} >> $urandom_range(1, W - 1));
            default: return rand_coef() | W'(2);
        endcase
    endfunction

    task automatic push_coef(logic [W-1:0] xa, logic [W-1:0] xb, logic [W-1:0] ya,
                             logic [W-1:0] yb, logic [W-1:0] q, logic last);
        coef_t c;
        c.xa = xa; c.xb = xb; c.ya = ya; c.yb = yb; c.q = q; c.last = last;
        pending_q.push_back(c);
    endtask

    // Driver: hold a refused transaction, else present the next one at falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_axis_tvalid && !s_axis_tready_q))
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, pending_q[0].q, pending_q[0].yb,
                                      pending_q[0].ya, pending_q[0].xb, pending_q[0].xa};
                    s_axis_tlast  <= pending_q[0].last;
                    void'(pending_q.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: hold off for a counted stretch, else stall at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Acceptance seen at the last rising edge
    always @(posedge clk)
    begin
        s_axis_tready_q <= 1'b1;
        if (s_axis_tvalid && !s_axis_tready)
            s_axis_tready_q <= 1'b0;
    end

    // Predict on accepted input transaction
    always @(posedge clk)
    begin
        coef_t c;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            c.xa = s_axis_tdata[W-1:0];
            c.xb = s_axis_tdata[2*W-1:W];
            c.ya = s_axis_tdata[3*W-1:2*W];
            c.yb = s_axis_tdata[4*W-1:3*W];
            c.q  = s_axis_tdata[5*W-1:4*W];
            c.last = s_axis_tlast;
            expected_q.push_back(tensor_product(c));
        end
    end

    // Monitor: compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        tensor_t got;
        tensor_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.t0 = m_axis_tdata[W-1:0];
            got.t1 = m_axis_tdata[2*W-1:W];
            got.t2 = m_axis_tdata[3*W-1:2*W];
            got.err = m_axis_tuser;
            got.last = m_axis_tlast;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                fail_cnt <= fail_cnt + 1;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r)
                begin
                    $display("%0t: mismatch t0 exp %h got %h, t1 exp %h got %h", $time,
                             exp_r.t0, got.t0, exp_r.t1, got.t1);
                    $display("%0t:   t2 exp %h got %h, err exp %b got %b, last exp %b got %b",
                             $time, exp_r.t2, got.t2, exp_r.err, got.err,
                             exp_r.last, got.last);
                    fail_cnt <= fail_cnt + 1;
                end
            end
        end
    end

    // Stimulus and phases
    initial
    begin
        logic [W-1:0] q;
        logic [W-1:0] ones;
        int           n_items;
        ones = {W{1'b1}};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        fail_cnt = 0;
        n_items = 0;
        s_axis_tready_q = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, out-of-range inputs, moduli zero, one, two
        q = ones;
        push_coef('0, '0, '0, '0, q, 1'b0);
        push_coef(q - 1, q - 1, q - 1, q - 1, q, 1'b1);
        push_coef(q - 1, W'(1), W'(1), q - 1, q, 1'b0);
        push_coef(ones, '0, '0, '0, q - 1, 1'b0);
        push_coef('0, ones, '0, '0, W'(7), 1'b0);
        push_coef('0, '0, ones, '0, W'(7), 1'b0);
        push_coef('0, '0, '0, ones, W'(7), 1'b1);
        push_coef(W'(5), W'(6), W'(7), W'(8), '0, 1'b0);
        push_coef('0, '0, '0, '0, '0, 1'b0);
        push_coef('0, '0, '0, '0, W'(1), 1'b0);
        push_coef(W'(3), '0, '0, '0, W'(1), 1'b0);
        push_coef(W'(1), W'(1), W'(1), W'(1), W'(2), 1'b0);
        push_coef(ones, ones, ones, ones, W'(2), 1'b1);
        push_coef(W'(12345), ones - 5, W'(7), W'(99), ones - 2, 1'b0);
        push_coef(q - 2, q - 3, q - 2, q - 3, q, 1'b0);
        push_coef(ones >> 1, (ones >> 1) + 1, W'(3), ones >> 2, ones >> 0, 1'b1);

        // Random phases: no idling, sender gaps, receiver stalls, both, long hold
        for (int ph = 0; ph < 5; ph++)
        begin
            wait (pending_q.size() == 0);
            n_items = 70;
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 55; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 55; end
                3: begin gap_pct = 10; stall_pct = 10; end
                default:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                    hold_cycles = 300;
                    n_items = 160;
                end
            endcase
            for (int i = 0; i < n_items; i++)
            begin
                q = rand_modulus();
                if ($urandom_range(0, 9) == 0)
                    push_coef(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                              ($urandom_range(0, 3) == 0) ? W'($urandom_range(0, 1)) : q,
                              1'($urandom()));
                else
                    push_coef(rand_below(q), rand_below(q), rand_below(q), rand_below(q),
                              q, ($urandom_range(0, 15) == 0));
            end
        end
        wait (pending_q.size() == 0);
        @(negedge clk);
        stall_pct = 0;
        wait (!s_axis_tvalid && expected_q.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_cnt == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
